>>> sv/poly1305_mac_macros.svh
// Assertion macros for the Poly1305 MAC block.
// Included by the top level; no other dependencies.
`ifndef POLY1305_MAC_MACROS_SVH
`define POLY1305_MAC_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define P1305_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define P1305_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define P1305_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define P1305_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

>>> sv/p1305_pkg.sv
// Shared types, constants and helpers for the Poly1305 MAC.
// No dependencies; used by every module of the block.
package p1305_pkg;

  localparam int LIMBS     = 5;   // radix 2^26 limbs of the accumulator
  localparam int LIMB_W    = 26;
  localparam int ACC_W     = 27;  // stored limb, one bit of headroom
  localparam int SUM_W     = 28;  // limb after adding a message block
  localparam int RMUL_W    = 29;  // 5 * r limb
  localparam int PROD_W    = SUM_W + RMUL_W;
  localparam int DSUM_W    = 61;  // five products plus row carry
  localparam int CARRY_W   = DSUM_W - LIMB_W;
  localparam int FOLD_W    = CARRY_W + 3;
  localparam int KEY_W     = 64;
  localparam int BLK_W     = 128;
  localparam int CNT_W     = 5;
  localparam int IN_W      = 136;
  localparam int CFG_IDX_W = 3;
  localparam int ROW_W     = 3;

  localparam logic [KEY_W-1:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
  localparam logic [KEY_W-1:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_R_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S_HIGH = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_FIN5
  } state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic             load;
    logic             issue;
    logic [ROW_W-1:0] row;
    logic             sum_en;
    logic [ROW_W-1:0] sum_row;
    logic             sum_first;
    logic             fold;
    logic             norm;
    logic             reduce;
    logic             select;
    logic             tag;
    state_t           state;
  } ctrl_t;

  // Message padding: returns {high pad bit, padded block}.
  // Full blocks keep all bytes and set 2^128; a short final block keeps
  // bytes below the count, places 0x01 at the count and drops 2^128.
  function automatic logic [BLK_W:0] pad_block(input logic [BLK_W-1:0] msg,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic             last);
    logic [BLK_W-1:0] m;
    logic             full;
    full = !last || cnt[CNT_W-1];
    for (int j = 0; j < BLK_W / 8; j++) begin
      if (full || (CNT_W'(j) < cnt)) begin
        m[8*j +: 8] = msg[8*j +: 8];
      end else if (CNT_W'(j) == cnt) begin
        m[8*j +: 8] = 8'h01;
      end else begin
        m[8*j +: 8] = 8'h00;
      end
    end
    return {full, m};
  endfunction

endpackage

>>> sv/p1305_mul_row.sv
// Shared multiplier row: five limb products of one row of h * r mod 2^130-5.
// Clamps r and builds the 5*r wrap terms. Depends on p1305_pkg.
module p1305_mul_row (
  input  logic                                               clk,
  input  logic                                               issue,
  input  logic [p1305_pkg::ROW_W-1:0]                        row,
  input  logic [p1305_pkg::KEY_W-1:0]                        r_low,
  input  logic [p1305_pkg::KEY_W-1:0]                        r_high,
  input  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::SUM_W-1:0]  h,
  output logic [p1305_pkg::LIMBS-1:0][p1305_pkg::PROD_W-1:0] prod
);

  logic [p1305_pkg::KEY_W-1:0]                        rl;
  logic [p1305_pkg::KEY_W-1:0]                        rh;
  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::LIMB_W-1:0] rlimb;
  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::RMUL_W-1:0] r5;
  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::RMUL_W-1:0] op;

  // Clamped key split into 26-bit limbs
  assign rl = r_low & p1305_pkg::CLAMP_LOW;
  assign rh = r_high & p1305_pkg::CLAMP_HIGH;
  assign rlimb[0] = rl[25:0];
  assign rlimb[1] = rl[51:26];
  assign rlimb[2] = {rh[13:0], rl[63:52]};
  assign rlimb[3] = rh[39:14];
  assign rlimb[4] = {2'b00, rh[63:40]};

  // 5*r limbs for terms that wrap past 2^130
  for (genvar k = 0; k < p1305_pkg::LIMBS; k++) begin : g_r5
    assign r5[k] = (p1305_pkg::RMUL_W'(rlimb[k]) << 2) + p1305_pkg::RMUL_W'(rlimb[k]);
  end

  // Lane i of row k pairs h[i] with r[k-i], or 5*r[k-i+5] on wrap
  for (genvar i = 0; i < p1305_pkg::LIMBS; i++) begin : g_lane
    logic [p1305_pkg::ROW_W-1:0] tap;
    logic                        wrap;

    always_comb begin
      wrap = row < p1305_pkg::ROW_W'(i);
      if (wrap) begin
        tap = p1305_pkg::ROW_W'(row + p1305_pkg::ROW_W'(p1305_pkg::LIMBS - i));
      end else begin
        tap = p1305_pkg::ROW_W'(row - p1305_pkg::ROW_W'(i));
      end
      case (tap)
        3'd0:    op[i] = wrap ? r5[0] : p1305_pkg::RMUL_W'(rlimb[0]);
        3'd1:    op[i] = wrap ? r5[1] : p1305_pkg::RMUL_W'(rlimb[1]);
        3'd2:    op[i] = wrap ? r5[2] : p1305_pkg::RMUL_W'(rlimb[2]);
        3'd3:    op[i] = wrap ? r5[3] : p1305_pkg::RMUL_W'(rlimb[3]);
        3'd4:    op[i] = wrap ? r5[4] : p1305_pkg::RMUL_W'(rlimb[4]);
        default: op[i] = '0;
      endcase
    end

    // Registered product
    always_ff @(posedge clk) begin
      if (issue) begin
        prod[i] <= p1305_pkg::PROD_W'(h[i]) * p1305_pkg::PROD_W'(op[i]);
      end
    end
  end

endmodule

>>> sv/p1305_ctrl.sv
// Sequencer for the Poly1305 MAC: row issue, carry fold and tag finish.
// Depends on p1305_pkg for the state and control types.
module p1305_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             absorb_req,
  input  logic             last_in,
  input  logic             out_free,
  output logic             in_ready,
  output p1305_pkg::ctrl_t ctl
);

  p1305_pkg::state_t              state;
  p1305_pkg::state_t              state_next;
  logic [p1305_pkg::ROW_W-1:0]    cnt;
  logic [p1305_pkg::ROW_W-1:0]    cnt_next;
  logic                           is_last;
  logic                           is_last_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= p1305_pkg::ST_IDLE;
      cnt     <= '0;
      is_last <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      is_last <= is_last_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    is_last_next = is_last;
    case (state)
      p1305_pkg::ST_IDLE: begin
        if (in_fire) begin
          is_last_next = last_in;
          cnt_next     = '0;
          state_next   = absorb_req ? p1305_pkg::ST_MUL : p1305_pkg::ST_FIN1;
        end
      end
      p1305_pkg::ST_MUL: begin
        cnt_next = cnt + 3'd1;
        if (cnt == p1305_pkg::ROW_W'(p1305_pkg::LIMBS)) begin
          state_next = p1305_pkg::ST_FOLD;
        end
      end
      p1305_pkg::ST_FOLD: state_next = is_last ? p1305_pkg::ST_FIN1 : p1305_pkg::ST_IDLE;
      p1305_pkg::ST_FIN1: state_next = p1305_pkg::ST_FIN2;
      p1305_pkg::ST_FIN2: state_next = p1305_pkg::ST_FIN3;
      p1305_pkg::ST_FIN3: state_next = p1305_pkg::ST_FIN4;
      p1305_pkg::ST_FIN4: state_next = p1305_pkg::ST_FIN5;
      p1305_pkg::ST_FIN5: begin
        if (out_free) begin
          state_next = p1305_pkg::ST_IDLE;
        end
      end
      default: state_next = p1305_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready      = (state == p1305_pkg::ST_IDLE);
    ctl           = '0;
    ctl.state     = state;
    ctl.row       = cnt;
    ctl.sum_row   = cnt - 3'd1;
    ctl.sum_first = (cnt == 3'd1);
    case (state)
      p1305_pkg::ST_IDLE: ctl.load = in_fire;
      p1305_pkg::ST_MUL: begin
        ctl.issue  = cnt < p1305_pkg::ROW_W'(p1305_pkg::LIMBS);
        ctl.sum_en = cnt != 3'd0;
      end
      p1305_pkg::ST_FOLD: ctl.fold = 1'b1;
      p1305_pkg::ST_FIN1, p1305_pkg::ST_FIN2: begin
        ctl.norm   = 1'b1;
        ctl.reduce = 1'b1;
      end
      p1305_pkg::ST_FIN3: ctl.norm = 1'b1;
      p1305_pkg::ST_FIN4: ctl.select = 1'b1;
      p1305_pkg::ST_FIN5: ctl.tag = out_free;
      default: ctl.load = 1'b0;
    endcase
  end

endmodule

>>> sv/poly1305_mac.sv
// Poly1305 one-time authenticator, top level: key registers, accumulator
// datapath, output register. Depends on p1305_pkg, p1305_mul_row,
// p1305_ctrl and poly1305_mac_macros.svh.
//
// Usage:
//   cfg_* writes the key: index 0/1 = r low/high (clamped inside),
//   index 2/3 = s low/high. Write only while the block is idle.
//   s_axis carries one 16-byte block per item; s_axis_tlast marks the
//   final block, whose byte count (0..16) selects the short-block pad.
//   m_axis carries the 16-byte tag, once per message, after the final item.
// Sequence:
//   s_axis_tready drops at accept and rises again after the multiplier
//   rows on the five-lane multiplier row (one row of h*r per cycle,
//   summed in the cycle after) and one carry-fold step.
//   A final item adds the finish steps: full reduction, the final subtract
//   and the s addition; a final item with a zero count skips the rows.
// Reset clears keys, the accumulator and the output valid flag.
// While the tag waits on m_axis_tready the next message may start; a new
// tag holds in the last finish step until the output register is free.
`include "poly1305_mac_macros.svh"

module poly1305_mac (
  input  logic                              clk,
  input  logic                              rst,
  // msg_low [63:0], msg_high [127:64], byte_count [132:128], zero [135:133]
  input  logic [p1305_pkg::IN_W-1:0]        s_axis_tdata,
  input  logic                              s_axis_tlast,  // last
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tag_low [63:0], tag_high [127:64]
  output logic [p1305_pkg::BLK_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [p1305_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [p1305_pkg::KEY_W-1:0]       cfg_data
);

  logic [p1305_pkg::KEY_W-1:0]                        r_low;
  logic [p1305_pkg::KEY_W-1:0]                        r_high;
  logic [p1305_pkg::KEY_W-1:0]                        s_low;
  logic [p1305_pkg::KEY_W-1:0]                        s_high;
  logic [p1305_pkg::ACC_W-1:0]                        acc [p1305_pkg::LIMBS];
  logic [p1305_pkg::ACC_W-1:0]                        acc_norm [p1305_pkg::LIMBS];
  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::SUM_W-1:0]  hin;
  logic [p1305_pkg::LIMBS-1:0][p1305_pkg::PROD_W-1:0] prod;
  logic [p1305_pkg::CARRY_W-1:0]                      carry;
  logic [p1305_pkg::DSUM_W-1:0]                       dsum;
  logic [p1305_pkg::FOLD_W-1:0]                       fold0;
  logic [p1305_pkg::BLK_W:0]                          padded;
  logic [p1305_pkg::BLK_W-1:0]                        fsel;
  logic [p1305_pkg::BLK_W+2:0]                        vfull;
  logic [p1305_pkg::BLK_W+3:0]                        gfull;
  logic [p1305_pkg::BLK_W-1:0]                        tag_sum;
  logic                                               in_fire;
  logic                                               absorb_req;
  logic                                               out_free;
  p1305_pkg::ctrl_t                                   ctl;

  assign in_fire    = s_axis_tvalid & s_axis_tready;
  assign absorb_req = !s_axis_tlast || (s_axis_tdata[132:128] != 5'd0);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready  = 1'b1;

  p1305_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .absorb_req (absorb_req),
    .last_in    (s_axis_tlast),
    .out_free   (out_free),
    .in_ready   (s_axis_tready),
    .ctl        (ctl)
  );

  p1305_mul_row u_mul_row (
    .clk    (clk),
    .issue  (ctl.issue),
    .row    (ctl.row),
    .r_low  (r_low),
    .r_high (r_high),
    .h      (hin),
    .prod   (prod)
  );

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
      s_low  <= '0;
      s_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        p1305_pkg::CFG_R_LOW:  r_low  <= cfg_data;
        p1305_pkg::CFG_R_HIGH: r_high <= cfg_data;
        p1305_pkg::CFG_S_LOW:  s_low  <= cfg_data;
        p1305_pkg::CFG_S_HIGH: s_high <= cfg_data;
        default: r_low <= r_low;
      endcase
    end
  end

  // Padded block and operand load (h + block + pad)
  assign padded = p1305_pkg::pad_block(s_axis_tdata[127:0], s_axis_tdata[132:128],
                                       s_axis_tlast);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hin[0] <= p1305_pkg::SUM_W'(acc[0]) + p1305_pkg::SUM_W'(padded[25:0]);
      hin[1] <= p1305_pkg::SUM_W'(acc[1]) + p1305_pkg::SUM_W'(padded[51:26]);
      hin[2] <= p1305_pkg::SUM_W'(acc[2]) + p1305_pkg::SUM_W'(padded[77:52]);
      hin[3] <= p1305_pkg::SUM_W'(acc[3]) + p1305_pkg::SUM_W'(padded[103:78]);
      hin[4] <= p1305_pkg::SUM_W'(acc[4]) + p1305_pkg::SUM_W'(padded[128:104]);
    end
  end

  // Row sum: five products plus the carry from the row below
  always_comb begin
    dsum = ctl.sum_first ? '0 : p1305_pkg::DSUM_W'(carry);
    for (int i = 0; i < p1305_pkg::LIMBS; i++) begin
      dsum = dsum + p1305_pkg::DSUM_W'(prod[i]);
    end
  end

  // Top carry folds back times five
  assign fold0 = p1305_pkg::FOLD_W'(acc[0]) + (p1305_pkg::FOLD_W'(carry) << 2)
               + p1305_pkg::FOLD_W'(carry);

  // Carry propagation across limbs, optional wrap of bits above 2^130
  always_comb begin
    logic [p1305_pkg::ACC_W:0] v;
    logic [1:0]                nc;
    nc = 2'd0;
    for (int i = 0; i < p1305_pkg::LIMBS - 1; i++) begin
      v           = {1'b0, acc[i]} + (p1305_pkg::ACC_W + 1)'(nc);
      acc_norm[i] = {1'b0, v[25:0]};
      nc          = v[27:26];
    end
    v = {1'b0, acc[4]} + (p1305_pkg::ACC_W + 1)'(nc);
    if (ctl.reduce) begin
      acc_norm[4] = {1'b0, v[25:0]};
      acc_norm[0] = acc_norm[0] + (p1305_pkg::ACC_W'(v[27:26]) << 2)
                  + p1305_pkg::ACC_W'(v[27:26]);
    end else begin
      acc_norm[4] = v[26:0];
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst || ctl.tag) begin
      for (int i = 0; i < p1305_pkg::LIMBS; i++) begin
        acc[i] <= '0;
      end
    end else if (ctl.sum_en) begin
      acc[ctl.sum_row] <= p1305_pkg::ACC_W'(dsum[25:0]);
    end else if (ctl.fold) begin
      acc[0] <= p1305_pkg::ACC_W'(fold0[25:0]);
      acc[1] <= acc[1] + p1305_pkg::ACC_W'(fold0[p1305_pkg::FOLD_W-1:26]);
    end else if (ctl.norm) begin
      for (int i = 0; i < p1305_pkg::LIMBS; i++) begin
        acc[i] <= acc_norm[i];
      end
    end
  end

  // Row carry
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      carry <= dsum[p1305_pkg::DSUM_W-1:26];
    end
  end

  // Final subtract of p when h >= 2^130 - 5
  assign vfull = {acc[4], acc[3][25:0], acc[2][25:0], acc[1][25:0], acc[0][25:0]};
  assign gfull = (p1305_pkg::BLK_W + 4)'(vfull) + (p1305_pkg::BLK_W + 4)'(5);

  always_ff @(posedge clk) begin
    if (ctl.select) begin
      fsel <= (gfull[131:130] != 2'b00) ? gfull[127:0] : vfull[127:0];
    end
  end

  // Tag = h + s mod 2^128, into the output register
  assign tag_sum = fsel + {s_high, s_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.tag) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tag) begin
      m_axis_tdata <= tag_sum;
    end
  end

  // Checks
  `P1305_ASSERT_IMP(a_row_order, clk, rst, ctl.sum_en, $past(ctl.issue) && ($past(ctl.row) == ctl.sum_row), "row sum without matching product")
  `P1305_ASSERT_NXT(a_tag_clears, clk, rst, ctl.tag, m_axis_tvalid && (acc[0] == '0) && (acc[1] == '0) && (acc[2] == '0) && (acc[3] == '0) && (acc[4] == '0), "accumulator not cleared after tag")
  `P1305_ASSERT_IMP(a_tag_source, clk, rst, $rose(m_axis_tvalid), $past(ctl.state == p1305_pkg::ST_FIN5), "tag valid outside finish step")

endmodule

>>> bench/p1305_tag_check.sv
// Tag checker for poly1305_mac: mirrors key writes and absorbed blocks,
// predicts each tag and compares it with the tag items on m_axis.
// Depends on p1305_pkg for port widths, clamp masks and register indexes.
module p1305_tag_check (
  input  logic                            clk,
  input  logic                            rst,
  // msg_low [63:0], msg_high [127:64], byte_count [132:128], zero [135:133]
  input  logic [p1305_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                            s_axis_tlast,  // last
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // tag_low [63:0], tag_high [127:64]
  input  logic [p1305_pkg::BLK_W-1:0]     m_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [p1305_pkg::KEY_W-1:0]     cfg_data,
  output int                              errors,
  output int                              pending
);

  // 2^130 - 5
  localparam logic [129:0] PRIME = {{126{1'b1}}, 4'b1011};

  logic [63:0]  key_r_low  = '0;
  logic [63:0]  key_r_high = '0;
  logic [63:0]  key_s_low  = '0;
  logic [63:0]  key_s_high = '0;
  logic [129:0] acc_model  = '0;   // kept fully reduced mod 2^130-5
  logic [127:0] tag_expected[$];
  int           fail_count = 0;

  // h = (h + block) * r mod 2^130-5, two folds and one conditional subtract
  function automatic logic [129:0] poly_absorb(input logic [129:0] acc,
                                               input logic [128:0] blk,
                                               input logic [127:0] r_key);
    logic [260:0] prod;
    logic [133:0] fold;
    prod = (261'(acc) + 261'(blk)) * 261'(r_key);
    fold = 134'(prod[129:0]) + 134'(prod[260:130]) * 134'd5;
    fold = 134'(fold[129:0]) + 134'(fold[133:130]) * 134'd5;
    if (fold >= 134'(PRIME)) begin
      fold = fold - 134'(PRIME);
    end
    return fold[129:0];
  endfunction

  task automatic report_failure(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : predict
    logic [127:0] r_key;
    logic [127:0] msg;
    logic [127:0] mask;
    logic [127:0] want;
    logic [4:0]   cnt;
    if (rst) begin
      key_r_low  = '0;
      key_r_high = '0;
      key_s_low  = '0;
      key_s_high = '0;
      acc_model  = '0;
      tag_expected.delete();
    end else begin
      r_key = {key_r_high & p1305_pkg::CLAMP_HIGH, key_r_low & p1305_pkg::CLAMP_LOW};

      // tag item: compare with the oldest prediction before adding new ones
      if (m_axis_tvalid && m_axis_tready) begin
        if (tag_expected.size() == 0) begin
          report_failure($sformatf("unexpected tag %h", m_axis_tdata));
        end else begin
          want = tag_expected.pop_front();
          if (m_axis_tdata[63:0] !== want[63:0]) begin
            report_failure($sformatf("tag_low got %h expected %h",
                                     m_axis_tdata[63:0], want[63:0]));
          end
          if (m_axis_tdata[127:64] !== want[127:64]) begin
            report_failure($sformatf("tag_high got %h expected %h",
                                     m_axis_tdata[127:64], want[127:64]));
          end
        end
      end

      // key register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          p1305_pkg::CFG_R_LOW:  key_r_low  = cfg_data;
          p1305_pkg::CFG_R_HIGH: key_r_high = cfg_data;
          p1305_pkg::CFG_S_LOW:  key_s_low  = cfg_data;
          p1305_pkg::CFG_S_HIGH: key_s_high = cfg_data;
          default: ;
        endcase
      end

      // message block item
      if (s_axis_tvalid && s_axis_tready) begin
        msg = s_axis_tdata[127:0];
        cnt = s_axis_tdata[132:128];
        if (!s_axis_tlast || cnt >= 5'd16) begin
          // full block with the 2^128 pad bit
          acc_model = poly_absorb(acc_model, {1'b1, msg}, r_key);
        end else if (cnt != 5'd0) begin
          // short final block: keep bytes below count, 0x01 at count
          mask = (128'd1 << (8 * cnt)) - 128'd1;
          acc_model = poly_absorb(acc_model,
                                  {1'b0, (msg & mask) | (128'd1 << (8 * cnt))},
                                  r_key);
        end
        if (s_axis_tlast) begin
          tag_expected.push_back(acc_model[127:0] + {key_s_high, key_s_low});
          acc_model = '0;
        end
      end
    end
    errors  <= fail_count;
    pending <= tag_expected.size();
  end

endmodule

>>> bench/tb_top.sv
// Top of the poly1305_mac bench: clock, reset, key writes, message stimulus,
// tag sink with random stalls, watchdog and verdict.
// Depends on p1305_pkg, poly1305_mac and p1305_tag_check.
module tb_top;

  localparam int ITEM_TARGET  = 800;
  localparam int IDLE_LIMIT   = 3000;  // cycles with no item accepted anywhere
  localparam int FLUSH_CYCLES = 20;    // drain margin after the last tag is taken
  localparam int HOLD_CYCLES  = 400;   // long tag sink hold-off
  localparam int HOLD_AT      = 300;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic [p1305_pkg::IN_W-1:0]      s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [p1305_pkg::BLK_W-1:0]     m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index     = p1305_pkg::CFG_R_LOW;
  logic [p1305_pkg::KEY_W-1:0]     cfg_data      = '0;

  int   errors;
  int   pending;
  int   items_sent  = 0;
  int   hold_req    = 0;
  int   idle_cycles = 0;
  logic burst       = 1'b0;   // no sender gaps for the current message

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  poly1305_mac i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  p1305_tag_check i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  // watchdog: give up when no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // random 64-bit word, with the extremes now and then
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (burst || sel < 65) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] cnt, input logic last);
    int gap;
    s_axis_tdata  <= {3'b000, cnt, hi, lo};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random message: non-final blocks with any count, then the final block
  task automatic send_message(input int blocks, input logic [4:0] final_cnt);
    for (int b = 0; b < blocks - 1; b++) begin
      send_block(pick_word(), pick_word(), 5'($urandom_range(0, 16)), 1'b0);
    end
    send_block(pick_word(), pick_word(), final_cnt, 1'b1);
  endtask

  // stop sending, wait for every tag, then let the datapath drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // write the selected key registers back to back
  task automatic write_keys(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh,
                            input logic [3:0] which);
    logic [63:0]                     vals[4];
    logic [p1305_pkg::CFG_IDX_W-1:0] idx[4];
    vals = '{rl, rh, sl, sh};
    idx  = '{p1305_pkg::CFG_R_LOW, p1305_pkg::CFG_R_HIGH,
             p1305_pkg::CFG_S_LOW, p1305_pkg::CFG_S_HIGH};
    for (int i = 0; i < 4; i++) begin
      if (which[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[i];
        cfg_data  <= vals[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // tag sink: random ready pattern, plus one long hold-off on request
  initial begin : tag_sink
    int seen;
    int len;
    seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (seen != hold_req) begin
        seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            m_axis_tready <= 1'b0;
            len = $urandom_range(1, 3);
          end
          3: begin
            m_axis_tready <= 1'b0;
            len = $urandom_range(20, 80);
          end
          4: begin
            m_axis_tready <= 1'b1;
            len = $urandom_range(100, 200);
          end
          default: begin
            m_axis_tready <= 1'b1;
            len = $urandom_range(1, 20);
          end
        endcase
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [4:0] short_counts[6];
    logic [4:0] final_cnt;
    logic [3:0] which;
    logic       hold_issued;
    int         blocks;
    short_counts = '{5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16};
    hold_issued  = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // keys still at reset value: r = 0 gives a tag of zero
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b1);

    // all-ones keys; empty final gives s alone, then every pad position kind
    wait_idle();
    write_keys('1, '1, '1, '1, 4'hf);
    send_block('0, '0, 5'd0, 1'b1);
    foreach (short_counts[i]) begin
      send_block('1, '1, short_counts[i], 1'b1);
    end
    send_block('0, '0, 5'd3, 1'b1);

    // count is ignored on non-final blocks; empty final after full blocks
    send_block(pick_word(), pick_word(), 5'd0, 1'b0);
    send_block(pick_word(), pick_word(), 5'd5, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);

    // key change in the middle of a message, one register at a time
    wait_idle();
    write_keys(pick_word(), pick_word(), pick_word(), pick_word(), 4'hf);
    send_block(pick_word(), pick_word(), 5'd16, 1'b0);
    send_block(pick_word(), pick_word(), 5'd2, 1'b0);
    wait_idle();
    write_keys(pick_word(), '0, '0, '0, 4'b0001);
    send_block(pick_word(), pick_word(), 5'd11, 1'b0);
    wait_idle();
    write_keys('0, '0, '0, pick_word(), 4'b1000);
    send_block(pick_word(), pick_word(), 5'd12, 1'b1);

    // random messages
    while (items_sent < ITEM_TARGET) begin
      // new keys now and then, never right around the sink hold-off
      if ($urandom_range(0, 3) == 0 && (items_sent < HOLD_AT || items_sent > HOLD_AT + 60)) begin
        wait_idle();
        which = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hf;
        case ($urandom_range(0, 5))
          0:       write_keys('0, '0, '0, '0, which);
          1:       write_keys('1, '1, '1, '1, which);
          default: write_keys(pick_word(), pick_word(), pick_word(), pick_word(), which);
        endcase
      end
      if (!hold_issued && items_sent >= HOLD_AT) begin
        hold_req++;
        hold_issued = 1'b1;
      end
      burst  = ($urandom_range(0, 3) == 0);
      blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      case ($urandom_range(0, 5))
        0:       final_cnt = 5'd0;
        1:       final_cnt = 5'd16;
        default: final_cnt = 5'($urandom_range(1, 15));
      endcase
      send_message(blocks, final_cnt);
    end

    // drain and verdict
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/p1305_pkg.sv
sv/p1305_mul_row.sv
sv/p1305_ctrl.sv
sv/poly1305_mac.sv
bench/p1305_tag_check.sv
bench/tb_top.sv
